// ===== hw/rtl/sfsr_pkg.sv =====
// Shared types and constants of the sentence framer slot ring.
package sfsr_pkg;

	// Item operation codes; code 3 is unused and leaves the state alone
	typedef enum logic [1:0] {
		OP_RECV    = 2'd0,
		OP_READ    = 2'd1,
		OP_RELEASE = 2'd2
	} opcode_t;

	// Configuration register indexes
	localparam logic CFG_START_CHAR = 1'b0;
	localparam logic CFG_END_CHAR   = 1'b1;

	localparam int          CFG_IDX_W        = 1;
	localparam int          CFG_DATA_W       = 8;
	localparam logic [7:0]  START_CHAR_RESET = 8'h24;
	localparam logic [7:0]  END_CHAR_RESET   = 8'h0A;
	localparam logic [7:0]  TERM_BYTE        = 8'h00;
	localparam int          MASK_SLOTS       = 8;

	// Parameter defaults
	localparam int NUM_SLOTS_DEF  = 8;
	localparam int SLOT_BYTES_DEF = 128;

	// Storage bank of a byte position inside a slot's data area
	typedef enum logic [1:0] {
		BANK_EVEN,
		BANK_ODD,
		BANK_LAST
	} bank_t;

	// Per-item status carried down the pipeline
	typedef struct packed {
		logic                  notify;
		logic                  sentence_done;
		logic [2:0]            done_slot;
		logic                  busy_drop;
		logic [MASK_SLOTS-1:0] full_mask;
	} status_t;

endpackage

// ===== hw/rtl/sentence_framer_slot_ring.sv =====
// Sentence framer: frames received bytes into a ring of slots with full flags.
//
// Input channel (in_valid/in_stall) carries one item per handshake: opcode 0
// receives byte_value, opcode 1 reads the stored byte at (slot, offset),
// opcode 2 releases a slot. Output channel (out_valid/out_stall) returns
// exactly one result item per input item, in order.
// A start byte opens a sentence in the current slot if that slot is free,
// else the item reports busy_drop. The end byte closes the sentence, stores
// a zero byte after it, marks the slot full and moves to the next slot.
// Throughput is one item per cycle unless in_stall is high: state is
// updated in the acceptance cycle and the slot store is split into even,
// odd and last-position banks so an end byte and its zero terminator are
// written in the same cycle, each bank with one write port. Two result
// registers, s1 and s2, sit between the sides, so an item is still taken
// while one finished result waits; in_stall rises only when both are held
// by out_stall. A stalled result holds its fields unchanged.
// Reset clears the open flag, write position, current slot, all full flags
// and restores start_char to '$' and end_char to line feed. Stored bytes
// are not cleared; configuration is written through cfg_we, and the user
// must write it only while the block is idle; the block does not enforce it.
module sentence_framer_slot_ring #(
	parameter int NUM_SLOTS  = sfsr_pkg::NUM_SLOTS_DEF,
	parameter int SLOT_BYTES = sfsr_pkg::SLOT_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [sfsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfsr_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     opcode,
	input  logic [7:0]                     byte_value,
	input  logic [2:0]                     slot,
	input  logic [6:0]                     offset,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           notify,
	output logic                           sentence_done,
	output logic [2:0]                     done_slot,
	output logic                           busy_drop,
	output logic [7:0]                     full_mask,
	output logic [7:0]                     read_data
);
	import sfsr_pkg::*;

	localparam int DATA_BYTES = SLOT_BYTES - 1;
	localparam int LAST_POS   = DATA_BYTES - 1;
	localparam int PW         = $clog2(DATA_BYTES);
	localparam int SW         = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int HW         = PW - 1;
	localparam int BANK_DEPTH = NUM_SLOTS << HW;
	localparam int BAW        = SW + HW;

	// Configuration registers
	logic [7:0] start_char_q, end_char_q;

	// Framer state
	logic                 open_q;
	logic [PW-1:0]        wpos_q;
	logic [SW-1:0]        cur_q;
	logic [NUM_SLOTS-1:0] full_q;

	// Next state
	logic                 open_d;
	logic [PW-1:0]        wpos_d;
	logic [SW-1:0]        cur_d;
	logic [NUM_SLOTS-1:0] full_d;

	// Slot store banks
	logic [7:0] even_mem_q [BANK_DEPTH];
	logic [7:0] odd_mem_q  [BANK_DEPTH];
	logic [7:0] last_mem_q [NUM_SLOTS];

	// Pipeline
	logic          in_accept, adv_s2;
	logic          valid_s1, valid_s2;
	status_t       stat_d, stat_s1, stat_s2;
	logic [MASK_SLOTS-1:0] stat_d_mask_bit;
	logic          rd_en_s1;
	bank_t         rd_bank_s1;
	logic [7:0]    rd_even_s1, rd_odd_s1, rd_last_s1;
	logic [7:0]    rdata_s2;

	// Item decode
	opcode_t       op;
	logic          is_start, is_end, wr_byte, closing, busy;
	logic [PW-1:0] pos0, pos1;
	bank_t         bank0, bank1;
	logic          rd_en;
	bank_t         rd_bank;
	logic [SW-1:0] rd_slot;
	logic [PW-1:0] rd_pos;
	logic          rel_en;

	// Bank write controls
	logic          we_even, we_odd, we_last;
	logic [BAW-1:0] waddr_even, waddr_odd;
	logic [7:0]    wdata_even, wdata_odd, wdata_last;
	logic [BAW-1:0] raddr_pair;

	// Map a data position to its bank
	function automatic bank_t bank_of(input logic [PW-1:0] p);
		bank_t b;
		if (p == PW'(LAST_POS))
			b = BANK_LAST;
		else if (p[0])
			b = BANK_ODD;
		else
			b = BANK_EVEN;
		return b;
	endfunction

	// Handshake
	assign in_stall  = valid_s1 && valid_s2 && out_stall;
	assign in_accept = in_valid && !in_stall;
	assign adv_s2    = valid_s1 && (!valid_s2 || !out_stall);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q <= START_CHAR_RESET;
			end_char_q   <= END_CHAR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_CHAR: start_char_q <= cfg_data;
				CFG_END_CHAR:   end_char_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decode the item and frame received bytes
	always_comb begin
		op       = opcode_t'(opcode);
		is_start = (byte_value == start_char_q);
		is_end   = (byte_value == end_char_q);
		wr_byte  = 1'b0;
		closing  = 1'b0;
		busy     = 1'b0;
		rd_en    = 1'b0;
		rel_en   = 1'b0;
		pos0     = is_start ? '0 : wpos_q;
		pos1     = (pos0 == PW'(LAST_POS)) ? '0 : pos0 + PW'(1);
		rd_slot  = SW'(slot);
		rd_pos   = PW'(offset);
		open_d   = open_q;
		wpos_d   = wpos_q;
		cur_d    = cur_q;
		full_d   = full_q;
		unique case (op)
			OP_RECV: begin
				if (open_q || (is_start && !full_q[cur_q]))
					wr_byte = 1'b1;
				else if (is_start)
					busy = 1'b1;
				closing = wr_byte && is_end;
				if (closing) begin
					full_d[cur_q] = 1'b1;
					cur_d  = (cur_q == SW'(NUM_SLOTS - 1)) ? '0 : cur_q + SW'(1);
					wpos_d = '0;
					open_d = 1'b0;
				end else if (wr_byte) begin
					wpos_d = pos1;
					open_d = 1'b1;
				end else begin
					wpos_d = pos0;
				end
			end
			OP_READ: begin
				rd_en = (32'(slot) < NUM_SLOTS) && (32'(offset) < DATA_BYTES);
			end
			OP_RELEASE: begin
				rel_en = (32'(slot) < NUM_SLOTS);
				if (rel_en)
					full_d[rd_slot] = 1'b0;
			end
			default: ;
		endcase
		bank0   = bank_of(pos0);
		bank1   = bank_of(pos1);
		rd_bank = bank_of(rd_pos);
	end

	// Status of the item after this step
	always_comb begin
		stat_d               = '0;
		stat_d.busy_drop     = busy;
		stat_d.sentence_done = closing;
		stat_d.notify        = busy || closing;
		stat_d.done_slot     = closing ? 3'(cur_q) : 3'd0;
		stat_d.full_mask     = stat_d_mask_bit;
	end

	for (genvar i = 0; i < MASK_SLOTS; i++) begin : g_mask
		if (i < NUM_SLOTS) begin : g_live
			assign stat_d_mask_bit[i] = full_d[i];
		end else begin : g_none
			assign stat_d_mask_bit[i] = 1'b0;
		end
	end

	// Steer the byte and its terminator to their banks
	always_comb begin
		we_even    = 1'b0;
		we_odd     = 1'b0;
		we_last    = 1'b0;
		waddr_even = {cur_q, pos0[PW-1:1]};
		waddr_odd  = {cur_q, pos0[PW-1:1]};
		wdata_even = byte_value;
		wdata_odd  = byte_value;
		wdata_last = byte_value;
		if (in_accept && wr_byte) begin
			case (bank0)
				BANK_EVEN: we_even = 1'b1;
				BANK_ODD:  we_odd  = 1'b1;
				default:   we_last = 1'b1;
			endcase
		end
		if (in_accept && closing) begin
			case (bank1)
				BANK_EVEN: begin
					we_even    = 1'b1;
					waddr_even = {cur_q, pos1[PW-1:1]};
					wdata_even = TERM_BYTE;
				end
				BANK_ODD: begin
					we_odd    = 1'b1;
					waddr_odd = {cur_q, pos1[PW-1:1]};
					wdata_odd = TERM_BYTE;
				end
				default: begin
					we_last    = 1'b1;
					wdata_last = TERM_BYTE;
				end
			endcase
		end
		raddr_pair = {rd_slot, rd_pos[PW-1:1]};
	end

	// Slot store banks: one write and one registered read each
	always_ff @(posedge clk) begin
		if (we_even)
			even_mem_q[waddr_even] <= wdata_even;
		if (in_accept && rd_en)
			rd_even_s1 <= even_mem_q[raddr_pair];
	end

	always_ff @(posedge clk) begin
		if (we_odd)
			odd_mem_q[waddr_odd] <= wdata_odd;
		if (in_accept && rd_en)
			rd_odd_s1 <= odd_mem_q[raddr_pair];
	end

	always_ff @(posedge clk) begin
		if (we_last)
			last_mem_q[cur_q] <= wdata_last;
		if (in_accept && rd_en)
			rd_last_s1 <= last_mem_q[rd_slot];
	end

	// Framer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			wpos_q <= '0;
			cur_q  <= '0;
			full_q <= '0;
		end else if (in_accept) begin
			open_q <= open_d;
			wpos_q <= wpos_d;
			cur_q  <= cur_d;
			full_q <= full_d;
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !adv_s2);
			valid_s2 <= adv_s2 || (valid_s2 && out_stall);
		end
	end

	// Stage payloads: load on advance, hold otherwise
	always_ff @(posedge clk) begin
		if (in_accept) begin
			stat_s1    <= stat_d;
			rd_en_s1   <= rd_en;
			rd_bank_s1 <= rd_bank;
		end
		if (adv_s2) begin
			stat_s2 <= stat_s1;
			if (!rd_en_s1)
				rdata_s2 <= 8'd0;
			else begin
				case (rd_bank_s1)
					BANK_EVEN: rdata_s2 <= rd_even_s1;
					BANK_ODD:  rdata_s2 <= rd_odd_s1;
					default:   rdata_s2 <= rd_last_s1;
				endcase
			end
		end
	end

	// Result ports
	assign out_valid     = valid_s2;
	assign notify        = stat_s2.notify;
	assign sentence_done = stat_s2.sentence_done;
	assign done_slot     = stat_s2.done_slot;
	assign busy_drop     = stat_s2.busy_drop;
	assign full_mask     = stat_s2.full_mask;
	assign read_data     = rdata_s2;

	// Checks
	a_done_busy_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(sentence_done && busy_drop))
		else $error("sentence_done and busy_drop on the same item");

	a_notify_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (notify == (sentence_done || busy_drop)))
		else $error("notify without a close or a drop");

	a_done_marks_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sentence_done) |-> full_mask[done_slot])
		else $error("closed slot not flagged full");

	a_closed_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (wpos_q == '0))
		else $error("write position moved while no sentence is open");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free result register");

endmodule
